FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue and its cells
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int ID_BITS  = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // command codes
    localparam logic [2:0] CMD_INSERT       = 3'd0;
    localparam logic [2:0] CMD_APPEND       = 3'd1;
    localparam logic [2:0] CMD_REMOVE       = 3'd2;
    localparam logic [2:0] CMD_CURSOR_RESET = 3'd3;
    localparam logic [2:0] CMD_CURSOR_NEXT  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_END       = 2'd3;

    // configuration register indexes
    localparam logic CFG_DESCENDING     = 1'b0;
    localparam logic CFG_USE_SECOND_KEY = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key_primary;
        logic [KEY_BITS-1:0] key_secondary;
    } entry_t;

    // broadcast control for every cell in the row
    typedef struct packed {
        logic insert;       // insert or append transfer, queue not full
        logic append;       // place at tail instead of sorted position
        logic remove;       // remove by id
        logic descending;
        logic use_second_key;
    } cell_ctl_t;

    // per-cell status handed down the row
    typedef struct packed {
        logic first;        // this cell is the first one that hit
        logic found;        // this cell or one before it hit
    } cell_stat_t;

endpackage

FILE: rtl/sorted_priority_queue_with_cursor.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_cursor
// bounded sorted queue of id/key entries with a traversal cursor
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, each holding one entry. Every command
// is handled by the whole row: all cells compare the incoming keys (or id)
// in parallel, a hit chain runs down the row to find the first hit, and each
// cell then loads the new item, takes its left or right neighbor, or holds.
// The result is registered and offered in the cycle after its command
// transfer. One command transfer is taken every cycle while the result side
// keeps up; a new command is taken in the same cycle that a waiting result
// transfers, and not while the result is held up. The cycle time is set by
// the key compare plus the hit chain through all cells. Configuration writes
// take effect on the next command.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_cursor (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd[2:0], item_id[10:3], key_primary[26:11],
                                   // key_secondary[42:27], zero fill
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[1:0], entry_valid[2], entry_id[10:3],
                                   // entry_key_primary[26:11],
                                   // entry_key_secondary[42:27], occupancy[47:43],
                                   // head_valid[48], head_id[56:49], zero fill
);
    import spq_pkg::*;

    // configuration
    logic descending_reg;
    logic use_second_key_reg;

    // queue control state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] cursor_pos_reg;
    logic [IDX_W-1:0] cursor_pos_next;
    logic             cursor_idle_reg;
    logic             cursor_idle_next;

    // output register
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    logic        accept;
    logic [2:0]  cmd;
    entry_t      new_entry;
    cell_ctl_t   ctl;
    logic        full;

    entry_t      cell_entry      [CAPACITY];
    entry_t      cell_entry_next [CAPACITY];
    cell_stat_t  cell_stat       [CAPACITY];
    logic [CAPACITY-1:0] occupied;

    // hit decode
    logic [IDX_W-1:0] hit_idx;
    logic             hit_occupied;   // first hit lies on a live entry
    logic             any_hit;

    // cursor read
    logic [CNT_W-1:0] next_pos;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;

    // result fields
    logic [1:0]         status;
    logic               entry_valid;
    entry_t             out_entry;
    logic               head_valid;
    logic [ID_BITS-1:0] head_id;

    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cmd                     = s_tdata[2:0];
    assign new_entry.id            = s_tdata[10:3];
    assign new_entry.key_primary   = s_tdata[26:11];
    assign new_entry.key_secondary = s_tdata[42:27];

    assign full = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        ctl.insert         = accept & ~full & ((cmd == CMD_INSERT) | (cmd == CMD_APPEND));
        ctl.append         = cmd == CMD_APPEND;
        ctl.remove         = accept & (cmd == CMD_REMOVE);
        ctl.descending     = descending_reg;
        ctl.use_second_key = use_second_key_reg;
    end

    // row of cells, hit chain ripples from head to tail
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   found_in;

        assign occupied[i] = count_reg > CNT_W'(i);

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
            assign found_in   = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign found_in   = cell_stat[i-1].found;
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (occupied[i]),
            .found_in    (found_in),
            .stat        (cell_stat[i]),
            .entry       (cell_entry[i]),
            .entry_next  (cell_entry_next[i])
        );
    end

    // index of the first hit from the one-hot first flags
    always_comb
    begin
        hit_idx      = '0;
        hit_occupied = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_stat[i].first)
            begin
                hit_idx      = hit_idx | IDX_W'(i);
                hit_occupied = hit_occupied | occupied[i];
            end
        end
        any_hit = cell_stat[CAPACITY-1].found;
    end

    // cursor next reads the entry after the cursor
    assign next_pos = cursor_idle_reg ? '0 : ({1'b0, cursor_pos_reg} + CNT_W'(1));
    assign rd_idx   = next_pos[IDX_W-1:0];

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_idx == IDX_W'(i))
                rd_entry = cell_entry[i];
        end
    end

    // command decode, cursor and count update
    always_comb
    begin
        count_next       = count_reg;
        cursor_pos_next  = cursor_pos_reg;
        cursor_idle_next = cursor_idle_reg;
        status           = ST_OK;
        entry_valid      = 1'b0;
        out_entry        = '0;

        unique case (cmd)
            CMD_INSERT, CMD_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    // sorted insert at or before the cursor pulls the cursor onto it
                    if ((cmd == CMD_INSERT) && hit_occupied && !cursor_idle_reg &&
                        (cursor_pos_reg >= hit_idx))
                        cursor_pos_next = hit_idx;
                end
            end
            CMD_REMOVE:
            begin
                if (!any_hit)
                    status = ST_NOT_FOUND;
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (!cursor_idle_reg)
                    begin
                        if (cursor_pos_reg == hit_idx)
                        begin
                            if (hit_idx == '0)
                            begin
                                cursor_idle_next = 1'b1;
                                cursor_pos_next  = '0;
                            end
                            else
                                cursor_pos_next = cursor_pos_reg - IDX_W'(1);
                        end
                        else if (cursor_pos_reg > hit_idx)
                            cursor_pos_next = cursor_pos_reg - IDX_W'(1);
                    end
                end
            end
            CMD_CURSOR_RESET:
            begin
                cursor_idle_next = 1'b1;
                cursor_pos_next  = '0;
            end
            CMD_CURSOR_NEXT:
            begin
                if (next_pos < count_reg)
                begin
                    cursor_idle_next = 1'b0;
                    cursor_pos_next  = rd_idx;
                    entry_valid      = 1'b1;
                    out_entry        = rd_entry;
                end
                else
                begin
                    cursor_idle_next = 1'b1;
                    cursor_pos_next  = '0;
                    status           = ST_END;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        head_valid = count_next != '0;
        head_id    = head_valid ? cell_entry_next[0].id : '0;

        out_data_next = {7'd0, head_id, head_valid, count_next,
                         out_entry.key_secondary, out_entry.key_primary,
                         out_entry.id, entry_valid, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg     <= 1'b0;
            use_second_key_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DESCENDING:     descending_reg     <= cfg_data;
                CFG_USE_SECOND_KEY: use_second_key_reg <= cfg_data;
                default:            descending_reg     <= descending_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            cursor_pos_reg  <= '0;
            cursor_idle_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg       <= count_next;
                cursor_pos_reg  <= cursor_pos_next;
                cursor_idle_reg <= cursor_idle_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one queue slot: compares against the incoming item and shifts with neighbors
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    input  logic               occupied,
    input  logic               found_in,
    output spq_pkg::cell_stat_t stat,
    output spq_pkg::entry_t    entry,
    output spq_pkg::entry_t    entry_next
);
    import spq_pkg::*;

    entry_t entry_reg;
    logic   precedes;
    logic   match;
    logic   flag;
    logic   p_gt;
    logic   p_lt;
    logic   p_eq;
    logic   s_gt;
    logic   s_lt;

    always_comb
    begin
        p_gt = $signed(new_entry.key_primary) > $signed(entry_reg.key_primary);
        p_lt = $signed(new_entry.key_primary) < $signed(entry_reg.key_primary);
        p_eq = new_entry.key_primary == entry_reg.key_primary;
        s_gt = $signed(new_entry.key_secondary) > $signed(entry_reg.key_secondary);
        s_lt = $signed(new_entry.key_secondary) < $signed(entry_reg.key_secondary);
        // new item strictly precedes this entry
        if (ctl.descending)
            precedes = p_gt | (ctl.use_second_key & p_eq & s_gt);
        else
            precedes = p_lt | (ctl.use_second_key & p_eq & s_lt);
        match = entry_reg.id == new_entry.id;

        if (ctl.remove)
            flag = occupied & match;
        else if (ctl.insert)
            flag = occupied ? (~ctl.append & precedes) : 1'b1;  // first empty slot
        else
            flag = 1'b0;

        stat.first = flag & ~found_in;
        stat.found = flag | found_in;

        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (found_in)
                entry_next = left_entry;
            else if (flag)
                entry_next = new_entry;
        end
        else if (ctl.remove)
        begin
            if (found_in | flag)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the sorted priority queue with cursor against its own queue model
// ----------------------------------------------------------------------------
// Commands go in on the slave stream with a random gap before each one. The
// master stream is stalled at random. Every accepted command is run through a
// model of the queue kept here: the entry row, the occupancy, the cursor and
// both config bits. The model's result is queued, and each result transfer is
// checked field by field against the oldest queued result. A directed part
// covers the empty queue, the cursor moves on insert and remove, and the full
// queue. Random traffic follows under every ordering setting. It swings
// between filling and draining the queue and uses few key values so that
// ties are common.
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    // codes that the block does not use and must leave without effect
    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

    // one result transfer, packed as m_tdata[56:0]
    typedef struct packed {
        logic [ID_BITS-1:0]  head_id;
        logic                head_valid;
        logic [CNT_W-1:0]    occupancy;
        logic [KEY_BITS-1:0] entry_key_secondary;
        logic [KEY_BITS-1:0] entry_key_primary;
        logic [ID_BITS-1:0]  entry_id;
        logic                entry_valid;
        logic [1:0]          status;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // cmd, item_id, key_primary, key_secondary, zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // status, entry_valid, entry_id, entry_key_primary,
                            // entry_key_secondary, occupancy, head_valid, head_id,
                            // zero fill

    // queue model
    logic [ID_BITS-1:0]         model_id [CAPACITY];
    logic signed [KEY_BITS-1:0] model_kp [CAPACITY];
    logic signed [KEY_BITS-1:0] model_ks [CAPACITY];
    int                         model_count = 0;
    int                         model_cursor = 0;
    bit                         model_cursor_idle = 1'b1;
    bit                         cfg_descending = 1'b0;
    bit                         cfg_second_key = 1'b0;

    queue_result_t pending_results [$];
    int            errors = 0;
    int            cycle_count = 0;
    int            send_gap_max = 9;
    int            ready_stall_max = 9;
    bit            filling = 1'b1;

    sorted_priority_queue_with_cursor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // true when new keys strictly come ahead of the entry keys
    function automatic bit comes_ahead(logic signed [KEY_BITS-1:0] a1,
                                       logic signed [KEY_BITS-1:0] a2,
                                       logic signed [KEY_BITS-1:0] b1,
                                       logic signed [KEY_BITS-1:0] b2);
        if (cfg_descending)
            return (a1 > b1) || (cfg_second_key && a1 == b1 && a2 > b2);
        return (a1 < b1) || (cfg_second_key && a1 == b1 && a2 < b2);
    endfunction

    // apply one command to the queue model and give back the result it causes
    function automatic queue_result_t predict_queue_result(logic [2:0] cmd,
                                                           logic [ID_BITS-1:0] id,
                                                           logic [KEY_BITS-1:0] k1,
                                                           logic [KEY_BITS-1:0] k2);
        queue_result_t r;
        int            pos;
        int            hit;
        int            step_to;
        r = '0;
        case (cmd)
            CMD_INSERT, CMD_APPEND:
            begin
                if (model_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    pos = model_count;
                    if (cmd == CMD_INSERT)
                    begin
                        for (int i = 0; i < model_count; i++)
                            if (pos == model_count &&
                                comes_ahead(k1, k2, model_kp[i], model_ks[i]))
                                pos = i;
                        // landing at or before the cursor pulls the cursor onto it
                        if (pos < model_count && !model_cursor_idle && model_cursor >= pos)
                            model_cursor = pos;
                    end
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_id[i] = model_id[i-1];
                        model_kp[i] = model_kp[i-1];
                        model_ks[i] = model_ks[i-1];
                    end
                    model_id[pos] = id;
                    model_kp[pos] = k1;
                    model_ks[pos] = k2;
                    model_count++;
                end
            end
            CMD_REMOVE:
            begin
                hit = model_count;
                for (int i = 0; i < model_count; i++)
                    if (hit == model_count && model_id[i] == id)
                        hit = i;
                if (hit == model_count)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    if (!model_cursor_idle)
                    begin
                        if (model_cursor == hit)
                        begin
                            // cursor steps back, or goes idle when it was on the head
                            if (hit == 0)
                            begin
                                model_cursor_idle = 1'b1;
                                model_cursor = 0;
                            end
                            else
                                model_cursor = hit - 1;
                        end
                        else if (model_cursor > hit)
                            model_cursor--;
                    end
                    for (int i = hit; i + 1 < model_count; i++)
                    begin
                        model_id[i] = model_id[i+1];
                        model_kp[i] = model_kp[i+1];
                        model_ks[i] = model_ks[i+1];
                    end
                    model_count--;
                end
            end
            CMD_CURSOR_RESET:
            begin
                model_cursor_idle = 1'b1;
                model_cursor = 0;
            end
            CMD_CURSOR_NEXT:
            begin
                step_to = model_cursor_idle ? 0 : model_cursor + 1;
                if (step_to < model_count)
                begin
                    model_cursor_idle = 1'b0;
                    model_cursor = step_to;
                    r.entry_valid = 1'b1;
                    r.entry_id = model_id[step_to];
                    r.entry_key_primary = model_kp[step_to];
                    r.entry_key_secondary = model_ks[step_to];
                end
                else
                begin
                    model_cursor_idle = 1'b1;
                    model_cursor = 0;
                    r.status = ST_END;
                end
            end
            default:
            begin
                // spare codes leave everything as it is
            end
        endcase
        r.occupancy = CNT_W'(model_count);
        r.head_valid = (model_count > 0);
        r.head_id = (model_count > 0) ? model_id[0] : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker, one comparison per result transfer
    always @(posedge clk)
    begin : result_checker
        queue_result_t got;
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[56:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
                check_field("entry_id", 32'(want.entry_id), 32'(got.entry_id));
                check_field("entry_key_primary", 32'(want.entry_key_primary),
                            32'(got.entry_key_primary));
                check_field("entry_key_secondary", 32'(want.entry_key_secondary),
                            32'(got.entry_key_secondary));
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                check_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                check_field("head_id", 32'(want.head_id), 32'(got.head_id));
            end
        end
    end

    // result side stalls a random number of cycles before each transfer
    initial
    begin : ready_driver
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, ready_stall_max);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // one command transfer after a random gap; valid stays up for a follow-on
    // command with no gap
    task automatic send_command(input logic [2:0] cmd, input logic [ID_BITS-1:0] id,
                                input logic [KEY_BITS-1:0] k1,
                                input logic [KEY_BITS-1:0] k2);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, k2, k1, id, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_queue_result(cmd, id, k1, k2));
    endtask

    // stop sending and let every queued result come back
    task automatic wait_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_DESCENDING)
            cfg_descending = value;
        else
            cfg_second_key = value;
    endtask

    // keys from the extremes, a few small values and at times any value, so that ties are common
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return {6'd0, 2'($urandom_range(0, 3)), 8'd0};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 7));    // duplicates on purpose
        return 8'($urandom_range(0, 255));
    endfunction

    // random commands that swing the queue between empty and full
    task automatic run_random_phase(input int items);
        int            roll;
        logic [2:0]    cmd;
        logic [ID_BITS-1:0] id;
        for (int n = 0; n < items; n++)
        begin
            if (model_count == 0)
                filling = 1'b1;
            else if (model_count == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if ($urandom_range(0, 49) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 40 : 10))
                cmd = CMD_INSERT;
            else if (roll < (filling ? 55 : 15))
                cmd = CMD_APPEND;
            else if (roll < 65)
                cmd = CMD_REMOVE;
            else if (roll < 90)
                cmd = CMD_CURSOR_NEXT;
            else if (roll < 95)
                cmd = CMD_CURSOR_RESET;
            else
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            id = pick_id();
            // removes mostly name an id that is in the queue
            if (cmd == CMD_REMOVE && model_count > 0 && $urandom_range(0, 3) != 0)
                id = model_id[$urandom_range(0, model_count - 1)];
            send_command(cmd, id, pick_key(), pick_key());
        end
    endtask

    // commands on an empty queue and a spare code
    task automatic test_empty_queue();
        send_command(CMD_CURSOR_NEXT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_REMOVE, 8'h05, 16'h0000, 16'h0000);
        send_command(CMD_SPARE_FIRST, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    // sorted placement with ties and the cursor following inserts and removes
    task automatic test_cursor_tracking();
        send_command(CMD_INSERT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_INSERT, 8'hFF, 16'h8000, 16'h7FFF);   // new head
        send_command(CMD_INSERT, 8'h11, 16'h7FFF, 16'h8000);   // new tail
        send_command(CMD_INSERT, 8'h22, 16'h0000, 16'hFFFF);   // tie, lands after
        send_command(CMD_APPEND, 8'h33, 16'hFB00, 16'h0000);   // out of order tail
        send_command(CMD_CURSOR_NEXT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_CURSOR_NEXT, 8'h00, 16'h0000, 16'h0000);
        // insert at the cursor's place pulls the cursor onto the new entry
        send_command(CMD_INSERT, 8'h44, 16'h8000, 16'h0000);
        // insert behind the cursor leaves it alone
        send_command(CMD_INSERT, 8'h55, 16'h0064, 16'h0000);
        send_command(CMD_CURSOR_NEXT, 8'h00, 16'h0000, 16'h0000);
        // remove the cursor's entry, then one ahead of it, then the head it sits on
        send_command(CMD_REMOVE, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_REMOVE, 8'hFF, 16'h0000, 16'h0000);
        send_command(CMD_REMOVE, 8'h44, 16'h0000, 16'h0000);
        send_command(CMD_CURSOR_NEXT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_CURSOR_RESET, 8'h00, 16'h0000, 16'h0000);
    endtask

    // fill to capacity, then both kinds of insert must be dropped
    task automatic test_full_queue();
        while (model_count < CAPACITY)
            send_command(CMD_INSERT, pick_id(), pick_key(), pick_key());
        send_command(CMD_INSERT, 8'hA5, 16'h8000, 16'h8000);
        send_command(CMD_APPEND, 8'h5A, 16'h7FFF, 16'h7FFF);
    endtask

    // random traffic under every ordering setting
    task automatic test_key_orders();
        for (int setting = 0; setting < 4; setting++)
        begin
            wait_until_drained();
            write_register(CFG_DESCENDING, setting[0]);
            write_register(CFG_USE_SECOND_KEY, setting[1]);
            run_random_phase(250);
        end
    endtask

    // full rate, then one side idling while the other does not
    task automatic test_back_to_back();
        send_gap_max = 0;
        ready_stall_max = 0;
        run_random_phase(120);
        // sender holds off until every result is back
        wait_until_drained();
        ready_stall_max = 9;
        run_random_phase(120);
        send_gap_max = 9;
        ready_stall_max = 0;
        run_random_phase(120);
        ready_stall_max = 9;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_register(CFG_DESCENDING, 1'b0);
        write_register(CFG_USE_SECOND_KEY, 1'b0);
        test_empty_queue();
        test_cursor_tracking();
        test_full_queue();
        test_key_orders();
        test_back_to_back();
        wait_until_drained();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
